// ----- src/bus_transaction_scheduler_defines.svh -----
// ---------------------------------------------------------------------------
// Bus transaction scheduler assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef BUS_TRANSACTION_SCHEDULER_DEFINES_SVH
`define BUS_TRANSACTION_SCHEDULER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/bts_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bus transaction scheduler package
// Transaction types, codes and the controller/datapath command types.
// ---------------------------------------------------------------------------
package bts_pkg;

  localparam logic [2:0] OP_SUBMIT   = 3'd0;
  localparam logic [2:0] OP_POLL     = 3'd1;
  localparam logic [2:0] OP_CANCEL   = 3'd2;
  localparam logic [2:0] OP_TICK     = 3'd3;
  localparam logic [2:0] OP_OUTCOME  = 3'd4;
  localparam logic [2:0] OP_SEND_EVT = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_NOT_READY = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_UNKNOWN   = 3'd4;

  localparam logic [2:0] R_OK       = 3'd0;
  localparam logic [2:0] R_EXC      = 3'd1;
  localparam logic [2:0] R_CRC      = 3'd2;
  localparam logic [2:0] R_PROTO    = 3'd3;
  localparam logic [2:0] R_TIMEOUT  = 3'd4;
  localparam logic [2:0] R_IO       = 3'd5;
  localparam logic [2:0] R_NOTREADY = 3'd6;
  localparam logic [2:0] R_INVALID  = 3'd7;

  localparam logic [2:0] EV_OK      = 3'd0;
  localparam logic [2:0] EV_EXC     = 3'd1;
  localparam logic [2:0] EV_CRC     = 3'd2;
  localparam logic [2:0] EV_PROTO   = 3'd3;
  localparam logic [2:0] EV_IO      = 3'd4;
  localparam logic [2:0] EV_INVALID = 3'd5;
  localparam logic [2:0] EV_COUNTER = 3'd6;

  localparam logic [1:0] TS_QUEUED   = 2'd0;
  localparam logic [1:0] TS_COMPLETE = 2'd1;
  localparam logic [1:0] TS_FAILED   = 2'd2;

  localparam logic [2:0] CNT_SUBMITTED = 3'd0;
  localparam logic [2:0] CNT_COMPLETED = 3'd1;
  localparam logic [2:0] CNT_CRC       = 3'd2;
  localparam logic [2:0] CNT_PROTO     = 3'd3;
  localparam logic [2:0] CNT_TIMEOUTS  = 3'd4;
  localparam logic [2:0] CNT_RETRIES   = 3'd5;
  localparam logic [2:0] CNT_IOERR     = 3'd6;
  localparam int         NUM_COUNTERS  = 7;

  localparam logic [15:0] AGING_RESET  = 16'd2000;
  localparam logic [15:0] TIMEOUT_MIN  = 16'd10;
  localparam logic [15:0] TIMEOUT_MAX  = 16'd5000;
  localparam logic [15:0] QUIET_MAX    = 16'd1000;
  localparam logic [15:0] GUARD_MAX    = 16'd5000;
  localparam logic [2:0]  PRIO_MAX     = 3'd3;
  localparam logic [2:0]  RETRY_MAX    = 3'd3;
  localparam logic [1:0]  PRIO_SAFETY  = 2'd3;
  localparam logic [2:0]  RANK_SAFETY  = 3'd4;
  localparam logic [2:0]  RANK_AGED    = 3'd3;

  typedef enum logic [1:0] {PH_FREE, PH_QUEUED, PH_ACTIVE, PH_FINISHED} phase_t;

  typedef enum logic [2:0] {
    K_NONE, K_SUBMIT, K_POLL, K_CANCEL, K_TICK, K_EVENT
  } kind_t;

  typedef enum logic [3:0] {
    AC_NONE, AC_LOAD, AC_SCAN, AC_ID_NEXT, AC_WRITE, AC_START, AC_TIMEOUT,
    AC_EVENT, AC_EMIT
  } act_t;

  typedef enum logic [2:0] {
    SC_FREE, SC_POLL, SC_CANCEL, SC_TICK, SC_ID_CHECK, SC_COUNT
  } scan_t;

  typedef enum logic [2:0] {
    CS_IDLE, CS_DISPATCH, CS_SCAN, CS_SCAN_END, CS_ID_NEXT, CS_APPLY, CS_EMIT
  } ctl_state_t;

  typedef struct packed {
    act_t  act;
    scan_t mode;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  found;
    logic  busy;
    logic  act_valid;
  } dp_status_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] now_ms;
    logic [7:0]  owner_id;
    logic [2:0]  priority_req;
    logic [15:0] timeout_ms;
    logic [2:0]  retry_limit;
    logic [15:0] quiet_ms;
    logic [15:0] guard_ms;
    logic [15:0] transaction_id;
    logic        enabled;
    logic        bus_quiet;
    logic [2:0]  event_code;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] result_id;
    logic [1:0]  txn_state;
    logic [2:0]  txn_result;
    logic        send_start;
    logic [2:0]  send_slot;
    logic [3:0]  queued_count;
    logic [31:0] counter_value;
  } out_item_t;

  function automatic logic [2:0] event_result(input logic [2:0] ev);
    logic [2:0] r;
    case (ev)
      EV_OK:    r = R_OK;
      EV_EXC:   r = R_EXC;
      EV_CRC:   r = R_CRC;
      EV_PROTO: r = R_PROTO;
      EV_IO:    r = R_IO;
      default:  r = R_INVALID;
    endcase
    return r;
  endfunction

endpackage

// ----- src/bts_in_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bus transaction scheduler request channel
// Valid/ready channel that carries one request transaction.
// ---------------------------------------------------------------------------
interface bts_in_if;
  logic             valid;
  logic             ready;
  bts_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/bts_out_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bus transaction scheduler result channel
// Valid/ready channel that carries one result transaction.
// ---------------------------------------------------------------------------
interface bts_out_if;
  logic              valid;
  logic              ready;
  bts_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/bts_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bus transaction scheduler controller
// Sequences loading, slot scans, ID allocation, slot updates and result hand-off.
// ---------------------------------------------------------------------------
module bts_ctrl #(
  parameter int QUEUE_DEPTH = 8,
  parameter int IW          = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output bts_pkg::cmd_t       cmd,
  output logic [IW-1:0]       idx,
  input  bts_pkg::dp_status_t st,
  input  logic [IW-1:0]       act_idx,
  input  logic [IW-1:0]       best_idx,
  input  logic [IW-1:0]       free_idx
);
  import bts_pkg::*;

  ctl_state_t    state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  scan_t         mode_r, mode_nxt;
  act_t          apply_r, apply_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          last;

  assign last      = (idx_r == IW'(QUEUE_DEPTH - 1));
  assign idx       = idx_r;
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == CS_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      idx_r       <= '0;
      mode_r      <= SC_COUNT;
      apply_r     <= AC_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      mode_r      <= mode_nxt;
      apply_r     <= apply_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    mode_nxt      = mode_r;
    apply_nxt     = apply_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.act       = AC_NONE;
    cmd.mode      = mode_r;
    case (state_r)
      CS_IDLE: begin
        if (in_valid) begin
          cmd.act   = AC_LOAD;
          state_nxt = CS_DISPATCH;
        end
      end
      CS_DISPATCH: begin
        idx_nxt   = '0;
        state_nxt = CS_SCAN;
        case (st.kind)
          K_SUBMIT: mode_nxt = SC_FREE;
          K_POLL:   mode_nxt = SC_POLL;
          K_CANCEL: mode_nxt = SC_CANCEL;
          K_TICK:   mode_nxt = SC_TICK;
          K_EVENT: begin
            idx_nxt   = act_idx;
            apply_nxt = AC_EVENT;
            state_nxt = CS_APPLY;
          end
          default:  mode_nxt = SC_COUNT;
        endcase
      end
      CS_SCAN: begin
        cmd.act = AC_SCAN;
        if (last) begin
          state_nxt = CS_SCAN_END;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      CS_SCAN_END: begin
        idx_nxt   = '0;
        mode_nxt  = SC_COUNT;
        state_nxt = CS_SCAN;
        case (mode_r)
          SC_FREE: begin
            if (st.found) state_nxt = CS_ID_NEXT;
          end
          SC_TICK: begin
            if (st.act_valid) begin
              idx_nxt   = act_idx;
              apply_nxt = AC_TIMEOUT;
              state_nxt = CS_APPLY;
            end else if (st.found) begin
              idx_nxt   = best_idx;
              apply_nxt = AC_START;
              state_nxt = CS_APPLY;
            end
          end
          SC_ID_CHECK: begin
            if (st.busy) begin
              state_nxt = CS_ID_NEXT;
            end else begin
              idx_nxt   = free_idx;
              apply_nxt = AC_WRITE;
              state_nxt = CS_APPLY;
            end
          end
          SC_COUNT: state_nxt = CS_EMIT;
          default:  state_nxt = CS_SCAN;
        endcase
      end
      CS_ID_NEXT: begin
        cmd.act   = AC_ID_NEXT;
        idx_nxt   = '0;
        mode_nxt  = SC_ID_CHECK;
        state_nxt = CS_SCAN;
      end
      CS_APPLY: begin
        cmd.act   = apply_r;
        idx_nxt   = '0;
        mode_nxt  = SC_COUNT;
        state_nxt = CS_SCAN;
      end
      CS_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.act       = AC_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

endmodule

// ----- src/bts_datapath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bus transaction scheduler datapath
// Slot table, counters, statistics and result registers, one slot per step.
// ---------------------------------------------------------------------------
module bts_datapath #(
  parameter int QUEUE_DEPTH = 8,
  parameter int IW          = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  input  bts_pkg::in_item_t    in_data,
  input  bts_pkg::cmd_t        cmd,
  input  logic [IW-1:0]        idx,
  output bts_pkg::dp_status_t  st,
  output logic [IW-1:0]        act_idx,
  output logic [IW-1:0]        best_idx,
  output logic [IW-1:0]        free_idx,
  output bts_pkg::out_item_t   out_data
);
  import bts_pkg::*;

  in_item_t    item_r;
  logic [15:0] aging_r;

  phase_t      phase_r  [QUEUE_DEPTH];
  logic [15:0] id_r     [QUEUE_DEPTH];
  logic [31:0] order_r  [QUEUE_DEPTH];
  logic [31:0] qtime_r  [QUEUE_DEPTH];
  logic [31:0] stime_r  [QUEUE_DEPTH];
  logic [7:0]  owner_r  [QUEUE_DEPTH];
  logic [1:0]  prio_r   [QUEUE_DEPTH];
  logic [12:0] tmo_r    [QUEUE_DEPTH];
  logic [1:0]  rlim_r   [QUEUE_DEPTH];
  logic [1:0]  att_r    [QUEUE_DEPTH];
  logic [9:0]  quiet_r  [QUEUE_DEPTH];
  logic [12:0] guard_r  [QUEUE_DEPTH];
  logic        aband_r  [QUEUE_DEPTH];
  logic [1:0]  ostate_r [QUEUE_DEPTH];
  logic [2:0]  ores_r   [QUEUE_DEPTH];

  logic [31:0] order_cnt_r;
  logic [15:0] id_cnt_r;
  logic [31:0] free_time_r;
  logic        act_valid_r;
  logic [IW-1:0] act_slot_r;
  logic        accepting_r;
  logic [31:0] stat_r [NUM_COUNTERS];

  kind_t       kind_r;
  logic        found_r;
  logic        busy_r;
  logic        sel_ok_r;
  logic [IW-1:0] best_r;
  logic [IW-1:0] free_r;
  logic [2:0]  best_rank_r;
  logic [31:0] best_order_r;
  logic [15:0] cand_r;

  logic [2:0]  status_r;
  logic [15:0] rid_r;
  logic [1:0]  tstate_r;
  logic [2:0]  tres_r;
  logic        sstart_r;
  logic [2:0]  sslot_r;
  logic [3:0]  qc_r;
  logic [31:0] cval_r;
  out_item_t   out_r;

  logic        bad_args;
  kind_t       load_kind;
  logic [2:0]  load_status;
  logic [31:0] load_cval;
  logic [31:0] free_diff;
  logic [31:0] age;
  logic [31:0] order_diff;
  logic [2:0]  rank;
  logic        ap_go;
  logic        ap_path;
  logic [2:0]  ap_res;
  logic        ap_retry;
  logic [31:0] gap_q;
  logic [31:0] gap_g;
  logic        ev_bad;

  assign st.kind      = kind_r;
  assign st.found     = found_r;
  assign st.busy      = busy_r;
  assign st.act_valid = act_valid_r;
  assign act_idx      = act_slot_r;
  assign best_idx     = best_r;
  assign free_idx     = free_r;
  assign out_data     = out_r;

  assign bad_args = (in_data.owner_id == 8'd0) || (in_data.priority_req > PRIO_MAX) ||
                    (in_data.timeout_ms < TIMEOUT_MIN) || (in_data.timeout_ms > TIMEOUT_MAX) ||
                    (in_data.retry_limit > RETRY_MAX) || (in_data.quiet_ms > QUIET_MAX) ||
                    (in_data.guard_ms > GUARD_MAX);
  assign ev_bad   = (in_data.event_code != EV_IO) && (in_data.event_code != EV_INVALID);
  assign free_diff = in_data.now_ms - free_time_r;

  always_comb begin
    load_kind   = K_NONE;
    load_status = ST_OK;
    load_cval   = '0;
    case (in_data.opcode)
      OP_SUBMIT: begin
        if (bad_args)          load_status = ST_INVALID;
        else if (!accepting_r) load_status = ST_NOT_READY;
        else begin
          load_status = ST_FULL;
          load_kind   = K_SUBMIT;
        end
      end
      OP_POLL: begin
        if (in_data.transaction_id == 16'd0) load_status = ST_INVALID;
        else begin
          load_status = ST_UNKNOWN;
          load_kind   = K_POLL;
        end
      end
      OP_CANCEL: begin
        if (in_data.owner_id != 8'd0) load_kind = K_CANCEL;
      end
      OP_TICK: load_kind = K_TICK;
      OP_OUTCOME: begin
        if (in_data.event_code > EV_INVALID) load_status = ST_INVALID;
        else if (!act_valid_r)               load_status = ST_NOT_READY;
        else                                 load_kind   = K_EVENT;
      end
      OP_SEND_EVT: begin
        if (in_data.event_code == EV_COUNTER) begin
          if (in_data.transaction_id < 16'(NUM_COUNTERS)) begin
            load_cval = stat_r[in_data.transaction_id[2:0]];
          end
        end else if (ev_bad)   load_status = ST_INVALID;
        else if (!act_valid_r) load_status = ST_NOT_READY;
        else                   load_kind   = K_EVENT;
      end
      default: load_status = ST_INVALID;
    endcase
  end

  assign age        = item_r.now_ms - qtime_r[idx];
  assign order_diff = order_r[idx] - best_order_r;
  assign rank       = (prio_r[idx] == PRIO_SAFETY) ? RANK_SAFETY :
                      (age >= {16'd0, aging_r}) ? RANK_AGED : {1'b0, prio_r[idx]};
  assign gap_q      = {22'd0, quiet_r[idx]};
  assign gap_g      = {19'd0, guard_r[idx]};

  always_comb begin
    ap_go   = 1'b0;
    ap_path = 1'b0;
    ap_res  = R_OK;
    case (cmd.act)
      AC_TIMEOUT: begin
        ap_go   = ((item_r.now_ms - stime_r[idx]) >= {19'd0, tmo_r[idx]});
        ap_path = 1'b1;
        ap_res  = R_TIMEOUT;
      end
      AC_EVENT: begin
        ap_go = 1'b1;
        if (item_r.opcode == OP_OUTCOME) begin
          ap_res  = event_result(item_r.event_code);
          ap_path = (item_r.event_code > EV_EXC);
        end else begin
          ap_res = (item_r.event_code == EV_IO) ? R_IO : R_INVALID;
        end
      end
      default: ap_go = 1'b0;
    endcase
    ap_retry = ap_go && ap_path && accepting_r && !aband_r[idx] && (ap_res != R_EXC) &&
               (att_r[idx] < rlim_r[idx]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aging_r     <= AGING_RESET;
      for (int i = 0; i < QUEUE_DEPTH; i++) phase_r[i] <= PH_FREE;
      for (int i = 0; i < NUM_COUNTERS; i++) stat_r[i] <= '0;
      order_cnt_r <= '0;
      id_cnt_r    <= '0;
      free_time_r <= '0;
      act_valid_r <= 1'b0;
      act_slot_r  <= '0;
      accepting_r <= 1'b0;
      kind_r      <= K_NONE;
      found_r     <= 1'b0;
      busy_r      <= 1'b0;
      sel_ok_r    <= 1'b0;
    end else begin
      if (cfg_we) aging_r <= cfg_wdata;
      case (cmd.act)
        AC_LOAD: begin
          item_r   <= in_data;
          kind_r   <= load_kind;
          status_r <= load_status;
          cval_r   <= load_cval;
          found_r  <= 1'b0;
          rid_r    <= '0;
          tstate_r <= TS_QUEUED;
          tres_r   <= R_OK;
          sstart_r <= 1'b0;
          sslot_r  <= '0;
          qc_r     <= '0;
          sel_ok_r <= !act_valid_r && !free_diff[31] &&
                      in_data.bus_quiet && in_data.enabled;
          if (in_data.opcode == OP_TICK) accepting_r <= in_data.enabled;
        end
        AC_SCAN: begin
          case (cmd.mode)
            SC_FREE: begin
              if (!found_r && phase_r[idx] == PH_FREE) begin
                found_r <= 1'b1;
                free_r  <= idx;
              end
            end
            SC_POLL: begin
              if (!found_r && phase_r[idx] != PH_FREE &&
                  id_r[idx] == item_r.transaction_id) begin
                found_r <= 1'b1;
                rid_r   <= item_r.transaction_id;
                if (phase_r[idx] != PH_FINISHED) begin
                  status_r <= ST_NOT_READY;
                  tstate_r <= TS_QUEUED;
                  tres_r   <= R_NOTREADY;
                end else begin
                  status_r     <= ST_OK;
                  tstate_r     <= ostate_r[idx];
                  tres_r       <= ores_r[idx];
                  phase_r[idx] <= PH_FREE;
                end
              end
            end
            SC_CANCEL: begin
              if (phase_r[idx] != PH_FREE && owner_r[idx] == item_r.owner_id) begin
                if (act_valid_r && act_slot_r == idx) aband_r[idx] <= 1'b1;
                else phase_r[idx] <= PH_FREE;
              end
            end
            SC_TICK: begin
              if (phase_r[idx] == PH_QUEUED) begin
                if (!item_r.enabled) begin
                  phase_r[idx]  <= PH_FINISHED;
                  ostate_r[idx] <= TS_FAILED;
                  ores_r[idx]   <= R_NOTREADY;
                end else if (sel_ok_r && (!found_r || rank > best_rank_r ||
                             (rank == best_rank_r && order_diff[31]))) begin
                  found_r      <= 1'b1;
                  best_r       <= idx;
                  best_rank_r  <= rank;
                  best_order_r <= order_r[idx];
                end
              end
            end
            SC_ID_CHECK: begin
              if (phase_r[idx] != PH_FREE && id_r[idx] == cand_r) busy_r <= 1'b1;
            end
            SC_COUNT: begin
              if (phase_r[idx] == PH_QUEUED || phase_r[idx] == PH_ACTIVE) qc_r <= qc_r + 4'd1;
            end
            default: busy_r <= busy_r;
          endcase
        end
        AC_ID_NEXT: begin
          busy_r <= 1'b0;
          if (id_cnt_r == 16'd0) begin
            cand_r   <= 16'd1;
            id_cnt_r <= 16'd2;
          end else begin
            cand_r   <= id_cnt_r;
            id_cnt_r <= id_cnt_r + 16'd1;
          end
        end
        AC_WRITE: begin
          phase_r[idx] <= PH_QUEUED;
          id_r[idx]    <= cand_r;
          order_r[idx] <= order_cnt_r;
          order_cnt_r  <= order_cnt_r + 32'd1;
          qtime_r[idx] <= item_r.now_ms;
          owner_r[idx] <= item_r.owner_id;
          prio_r[idx]  <= item_r.priority_req[1:0];
          tmo_r[idx]   <= item_r.timeout_ms[12:0];
          rlim_r[idx]  <= item_r.retry_limit[1:0];
          att_r[idx]   <= 2'd0;
          quiet_r[idx] <= item_r.quiet_ms[9:0];
          guard_r[idx] <= item_r.guard_ms[12:0];
          aband_r[idx] <= 1'b0;
          stat_r[CNT_SUBMITTED] <= stat_r[CNT_SUBMITTED] + 32'd1;
          rid_r    <= cand_r;
          status_r <= ST_OK;
        end
        AC_START: begin
          phase_r[idx] <= PH_ACTIVE;
          stime_r[idx] <= item_r.now_ms;
          act_valid_r  <= 1'b1;
          act_slot_r   <= idx;
          sstart_r     <= 1'b1;
          sslot_r      <= 3'(idx);
        end
        AC_TIMEOUT, AC_EVENT: begin
          if (ap_go && ap_path) begin
            if (ap_res == R_CRC)     stat_r[CNT_CRC] <= stat_r[CNT_CRC] + 32'd1;
            if (ap_res == R_PROTO)   stat_r[CNT_PROTO] <= stat_r[CNT_PROTO] + 32'd1;
            if (ap_res == R_TIMEOUT) stat_r[CNT_TIMEOUTS] <= stat_r[CNT_TIMEOUTS] + 32'd1;
          end
          if (ap_retry) begin
            att_r[idx]   <= att_r[idx] + 2'd1;
            stat_r[CNT_RETRIES] <= stat_r[CNT_RETRIES] + 32'd1;
            phase_r[idx] <= PH_QUEUED;
            order_r[idx] <= order_cnt_r;
            order_cnt_r  <= order_cnt_r + 32'd1;
            act_valid_r  <= 1'b0;
            free_time_r  <= item_r.now_ms + gap_g + gap_q;
          end else if (ap_go) begin
            ostate_r[idx] <= (ap_res == R_OK) ? TS_COMPLETE : TS_FAILED;
            ores_r[idx]   <= ap_res;
            free_time_r   <= item_r.now_ms + gap_q +
                             (((ap_res != R_OK) || aband_r[idx]) ? gap_g : 32'd0);
            phase_r[idx]  <= aband_r[idx] ? PH_FREE : PH_FINISHED;
            act_valid_r   <= 1'b0;
            if (ap_res == R_OK) stat_r[CNT_COMPLETED] <= stat_r[CNT_COMPLETED] + 32'd1;
            if (ap_res == R_IO && !ap_path) stat_r[CNT_IOERR] <= stat_r[CNT_IOERR] + 32'd1;
          end
        end
        AC_EMIT: begin
          out_r.status        <= status_r;
          out_r.result_id     <= rid_r;
          out_r.txn_state     <= tstate_r;
          out_r.txn_result    <= tres_r;
          out_r.send_start    <= sstart_r;
          out_r.send_slot     <= sslot_r;
          out_r.queued_count  <= qc_r;
          out_r.counter_value <= cval_r;
        end
        default: kind_r <= kind_r;
      endcase
    end
  end

endmodule

// ----- src/bus_transaction_scheduler.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bus transaction scheduler
// Slot table that queues, schedules, times out and retries bus transactions.
// ---------------------------------------------------------------------------
//   channel   direction  handshake            contents
//   in_txn    sink       valid/ready          one request transaction
//   out_txn   source     valid/ready          one result transaction
//   cfg       sink       cfg_we, no wait      aging limit in ms
//
// One transaction is worked at a time through a single shared slot port.
// Each slot scan visits every slot in turn; every transaction ends with a
// count scan, which follows a slot scan for a submit, poll, cancel or tick
// request. A slot start, timeout check or event adds an apply step; a submit
// adds an ID step and an ID check scan for each ID candidate tested, and an
// apply step for the slot write.
// A finished result waits in the output register while the next request is taken.
// Reset is synchronous and active low; all slots come up free.
// ---------------------------------------------------------------------------
`include "bus_transaction_scheduler_defines.svh"

module bus_transaction_scheduler #(
  parameter int QUEUE_DEPTH = 8
) (
  input logic        clk,
  input logic        rst_n,
  bts_in_if.sink     in_txn,
  bts_out_if.source  out_txn,
  input logic        cfg_we,
  input logic [15:0] cfg_wdata
);
  import bts_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);

  cmd_t          cmd;
  dp_status_t    st;
  logic [IW-1:0] idx;
  logic [IW-1:0] act_idx;
  logic [IW-1:0] best_idx;
  logic [IW-1:0] free_idx;

  bts_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .IW         (IW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_txn.valid),
    .in_ready (in_txn.ready),
    .out_valid(out_txn.valid),
    .out_ready(out_txn.ready),
    .cmd      (cmd),
    .idx      (idx),
    .st       (st),
    .act_idx  (act_idx),
    .best_idx (best_idx),
    .free_idx (free_idx)
  );

  bts_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .IW         (IW)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_data  (in_txn.data),
    .cmd      (cmd),
    .idx      (idx),
    .st       (st),
    .act_idx  (act_idx),
    .best_idx (best_idx),
    .free_idx (free_idx),
    .out_data (out_txn.data)
  );

  `BTS_ASSERT_NEXT(a_busy_after_accept, in_txn.valid && in_txn.ready, !in_txn.ready, "request taken while busy")
  `BTS_ASSERT_NOW(a_start_is_tick, out_txn.valid && out_txn.data.send_start, out_txn.data.status == ST_OK && out_txn.data.result_id == 16'd0, "send start with other result fields")
  `BTS_ASSERT_NOW(a_count_range, out_txn.valid, {1'b0, out_txn.data.queued_count} <= 5'(QUEUE_DEPTH), "queued count beyond depth")

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bus transaction scheduler testbench
// Drives request transactions through the valid/ready channel, predicts each
// result with a behavioral slot table model and checks every result field.
// Random idling on both sides, a long receiver hold-off and several aging
// limit settings are applied between phases.
// ---------------------------------------------------------------------------
module tb;
  import bts_pkg::*;

  localparam logic [2:0] OP_UNUSED_A = 3'd6;
  localparam logic [2:0] OP_UNUSED_B = 3'd7;

  class slot_scoreboard;
    logic [15:0] aging;
    phase_t      ph[8];
    logic [15:0] sid[8];
    logic [31:0] sord[8];
    logic [31:0] sque[8];
    logic [31:0] ssent[8];
    logic [7:0]  sown[8];
    logic [1:0]  spri[8];
    logic [15:0] stmo[8];
    logic [1:0]  srl[8];
    logic [1:0]  satt[8];
    logic [15:0] squi[8];
    logic [15:0] sgrd[8];
    bit          sab[8];
    logic [1:0]  ost[8];
    logic [2:0]  ores[8];
    logic [31:0] ordc;
    logic [15:0] idc;
    logic [31:0] bus_free;
    int          act;
    bit          actv;
    bit          acc;
    logic [31:0] cnt[NUM_COUNTERS];
    out_item_t   pending[$];
    int          errors;
    int          checked;
    int          starts;

    function new();
      aging = AGING_RESET;
      for (int i = 0; i < 8; i++) clear(i);
      ordc = 0;
      idc = 0;
      bus_free = 0;
      act = 0;
      actv = 0;
      acc = 0;
      for (int i = 0; i < NUM_COUNTERS; i++) cnt[i] = 0;
      errors = 0;
      checked = 0;
      starts = 0;
    endfunction

    function void clear(int i);
      ph[i] = PH_FREE;
      sid[i] = 0;
      sord[i] = 0;
      sque[i] = 0;
      ssent[i] = 0;
      sown[i] = 0;
      spri[i] = 0;
      stmo[i] = 0;
      srl[i] = 0;
      satt[i] = 0;
      squi[i] = 0;
      sgrd[i] = 0;
      sab[i] = 0;
      ost[i] = 0;
      ores[i] = 0;
    endfunction

    function int rank(int i, logic [31:0] now);
      logic [31:0] age;
      age = now - sque[i];
      if (spri[i] == PRIO_SAFETY) return RANK_SAFETY;
      if (age >= {16'd0, aging}) return RANK_AGED;
      return spri[i];
    endfunction

    function bit id_busy(logic [15:0] id);
      for (int i = 0; i < 8; i++)
        if (ph[i] != PH_FREE && sid[i] == id) return 1;
      return 0;
    endfunction

    function logic [15:0] next_id();
      logic [15:0] c;
      forever begin
        c = idc;
        idc++;
        if (c == 0) begin
          c = idc;
          idc++;
        end
        if (!id_busy(c)) return c;
      end
    endfunction

    function void finish(int i, logic [2:0] res, logic [31:0] now);
      ost[i] = (res == R_OK) ? TS_COMPLETE : TS_FAILED;
      ores[i] = res;
      bus_free = now + squi[i];
      if (res != R_OK || sab[i]) bus_free = bus_free + sgrd[i];
      if (sab[i]) clear(i);
      else ph[i] = PH_FINISHED;
      actv = 0;
      if (res == R_OK) cnt[CNT_COMPLETED]++;
    endfunction

    function void retry_or_finish(int i, logic [2:0] res, logic [31:0] now);
      if (res == R_CRC) cnt[CNT_CRC]++;
      if (res == R_PROTO) cnt[CNT_PROTO]++;
      if (res == R_TIMEOUT) cnt[CNT_TIMEOUTS]++;
      if (acc && !sab[i] && res != R_EXC && satt[i] < srl[i]) begin
        satt[i]++;
        cnt[CNT_RETRIES]++;
        ph[i] = PH_QUEUED;
        sord[i] = ordc;
        ordc++;
        actv = 0;
        bus_free = now + sgrd[i] + squi[i];
      end else begin
        finish(i, res, now);
      end
    endfunction

    function int pick_next(logic [31:0] now);
      int sel;
      int rc;
      int rs;
      logic [31:0] d;
      sel = -1;
      for (int i = 0; i < 8; i++) begin
        if (ph[i] != PH_QUEUED) continue;
        if (sel < 0) begin
          sel = i;
          continue;
        end
        rc = rank(i, now);
        rs = rank(sel, now);
        d = sord[i] - sord[sel];
        if (rc > rs || (rc == rs && d[31])) sel = i;
      end
      return sel;
    endfunction

    function logic [2:0] map_event(logic [2:0] ev);
      case (ev)
        EV_OK:    return R_OK;
        EV_EXC:   return R_EXC;
        EV_CRC:   return R_CRC;
        EV_PROTO: return R_PROTO;
        EV_IO:    return R_IO;
        default:  return R_INVALID;
      endcase
    endfunction

    function logic [15:0] live_id();
      int i;
      i = $urandom_range(0, 7);
      return (ph[i] != PH_FREE) ? sid[i] : 16'($urandom_range(1, 40));
    endfunction

    function void note_request(in_item_t it);
      out_item_t o;
      int f;
      int s;
      logic [31:0] d;
      logic [31:0] now;
      now = it.now_ms;
      o = '0;
      case (it.opcode)
        OP_SUBMIT: begin
          if (it.owner_id == 0 || it.priority_req > PRIO_MAX ||
              it.timeout_ms < TIMEOUT_MIN || it.timeout_ms > TIMEOUT_MAX ||
              it.retry_limit > RETRY_MAX || it.quiet_ms > QUIET_MAX ||
              it.guard_ms > GUARD_MAX) begin
            o.status = ST_INVALID;
          end else if (!acc) begin
            o.status = ST_NOT_READY;
          end else begin
            f = -1;
            for (int i = 0; i < 8; i++)
              if (f < 0 && ph[i] == PH_FREE) f = i;
            if (f < 0) begin
              o.status = ST_FULL;
            end else begin
              o.result_id = next_id();
              clear(f);
              ph[f] = PH_QUEUED;
              sid[f] = o.result_id;
              sord[f] = ordc;
              ordc++;
              sque[f] = now;
              sown[f] = it.owner_id;
              spri[f] = it.priority_req[1:0];
              stmo[f] = it.timeout_ms;
              srl[f] = it.retry_limit[1:0];
              squi[f] = it.quiet_ms;
              sgrd[f] = it.guard_ms;
              cnt[CNT_SUBMITTED]++;
            end
          end
        end
        OP_POLL: begin
          if (it.transaction_id == 0) begin
            o.status = ST_INVALID;
          end else begin
            o.status = ST_UNKNOWN;
            f = -1;
            for (int i = 0; i < 8; i++)
              if (f < 0 && ph[i] != PH_FREE && sid[i] == it.transaction_id) f = i;
            if (f >= 0) begin
              o.result_id = it.transaction_id;
              if (ph[f] != PH_FINISHED) begin
                o.status = ST_NOT_READY;
                o.txn_state = TS_QUEUED;
                o.txn_result = R_NOTREADY;
              end else begin
                o.status = ST_OK;
                o.txn_state = ost[f];
                o.txn_result = ores[f];
                clear(f);
              end
            end
          end
        end
        OP_CANCEL: begin
          if (it.owner_id != 0)
            for (int i = 0; i < 8; i++) begin
              if (ph[i] == PH_FREE || sown[i] != it.owner_id) continue;
              if (actv && act == i) sab[i] = 1;
              else clear(i);
            end
        end
        OP_TICK: begin
          acc = it.enabled;
          if (!it.enabled)
            for (int i = 0; i < 8; i++)
              if (ph[i] == PH_QUEUED) begin
                ost[i] = TS_FAILED;
                ores[i] = R_NOTREADY;
                ph[i] = PH_FINISHED;
              end
          if (!actv) begin
            d = now - bus_free;
            if (!d[31] && it.bus_quiet) begin
              s = pick_next(now);
              if (s >= 0) begin
                actv = 1;
                act = s;
                ph[s] = PH_ACTIVE;
                ssent[s] = now;
                o.send_start = 1;
                o.send_slot = 3'(s);
                starts++;
              end
            end
          end else begin
            d = now - ssent[act];
            if (d >= {16'd0, stmo[act]}) retry_or_finish(act, R_TIMEOUT, now);
          end
        end
        OP_OUTCOME: begin
          if (it.event_code > EV_INVALID) o.status = ST_INVALID;
          else if (!actv) o.status = ST_NOT_READY;
          else if (it.event_code <= EV_EXC) finish(act, map_event(it.event_code), now);
          else retry_or_finish(act, map_event(it.event_code), now);
        end
        OP_SEND_EVT: begin
          if (it.event_code == EV_COUNTER) begin
            o.counter_value = (it.transaction_id < NUM_COUNTERS) ?
                              cnt[it.transaction_id] : 32'd0;
          end else if (it.event_code != EV_IO && it.event_code != EV_INVALID) begin
            o.status = ST_INVALID;
          end else if (!actv) begin
            o.status = ST_NOT_READY;
          end else if (it.event_code == EV_IO) begin
            cnt[CNT_IOERR]++;
            finish(act, R_IO, now);
          end else begin
            finish(act, R_INVALID, now);
          end
        end
        default: o.status = ST_INVALID;
      endcase
      for (int i = 0; i < 8; i++)
        if (ph[i] == PH_QUEUED || ph[i] == PH_ACTIVE) o.queued_count++;
      pending.push_back(o);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("result with no pending expectation");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, got.status);
        errors++;
      end
      if (got.result_id !== e.result_id) begin
        $error("result_id: expected %0d, actual %0d", e.result_id, got.result_id);
        errors++;
      end
      if (got.txn_state !== e.txn_state) begin
        $error("txn_state: expected %0d, actual %0d", e.txn_state, got.txn_state);
        errors++;
      end
      if (got.txn_result !== e.txn_result) begin
        $error("txn_result: expected %0d, actual %0d", e.txn_result, got.txn_result);
        errors++;
      end
      if (got.send_start !== e.send_start) begin
        $error("send_start: expected %0d, actual %0d", e.send_start, got.send_start);
        errors++;
      end
      if (got.send_slot !== e.send_slot) begin
        $error("send_slot: expected %0d, actual %0d", e.send_slot, got.send_slot);
        errors++;
      end
      if (got.queued_count !== e.queued_count) begin
        $error("queued_count: expected %0d, actual %0d", e.queued_count,
               got.queued_count);
        errors++;
      end
      if (got.counter_value !== e.counter_value) begin
        $error("counter_value: expected %0d, actual %0d", e.counter_value,
               got.counter_value);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;

  bts_in_if  req_ch ();
  bts_out_if rsp_ch ();

  bus_transaction_scheduler #(.QUEUE_DEPTH(8)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_txn    (req_ch),
    .out_txn   (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  slot_scoreboard sb;
  bit          idling;
  bit          hold_req;
  logic [31:0] clock_ms;
  int          sent;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("** bus_transaction_scheduler: FAILED **");
    $finish;
  end

  // Result side: check accepted transactions and apply backpressure.
  initial begin : result_side
    int burst;
    int hold;
    burst = 0;
    hold = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.data);
      if (hold_req) begin
        hold_req = 0;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        rsp_ch.ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        rsp_ch.ready <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 12) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_req(input in_item_t it);
    if (idling && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= it;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(it);
    sent++;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_aging(input logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.aging = v;
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t base_req(input logic [2:0] op);
    in_item_t it;
    it = '0;
    it.opcode = op;
    it.now_ms = clock_ms;
    it.owner_id = 8'd1;
    it.timeout_ms = 16'd100;
    it.enabled = 1'b1;
    it.bus_quiet = 1'b1;
    return it;
  endfunction

  function automatic in_item_t rand_req();
    in_item_t it;
    int pick;
    logic [159:0] raw;
    if ($urandom_range(0, 99) == 0) clock_ms = clock_ms + $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 150);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it = base_req(OP_SUBMIT);
      it.owner_id = 8'($urandom_range(1, 4));
      it.priority_req = 3'($urandom_range(0, 3));
      it.timeout_ms = 16'($urandom_range(10, 300));
      it.retry_limit = 3'($urandom_range(0, 3));
      it.quiet_ms = 16'($urandom_range(0, 60));
      it.guard_ms = 16'($urandom_range(0, 60));
      if ($urandom_range(0, 9) == 0) begin
        it.owner_id = 8'($urandom);
        it.priority_req = 3'($urandom);
        it.timeout_ms = 16'($urandom);
        it.retry_limit = 3'($urandom);
        it.quiet_ms = 16'($urandom);
        it.guard_ms = 16'($urandom);
      end
    end else if (pick < 60) begin
      it = base_req(OP_TICK);
      it.enabled = ($urandom_range(0, 29) != 0);
      it.bus_quiet = ($urandom_range(0, 9) != 0);
    end else if (pick < 75) begin
      it = base_req(OP_OUTCOME);
      it.event_code = 3'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 5));
    end else if (pick < 83) begin
      it = base_req(OP_SEND_EVT);
      it.event_code = 3'($urandom_range(0, 2) == 0 ? $urandom_range(4, 5) : EV_COUNTER);
      it.transaction_id = 16'($urandom_range(0, 7));
    end else if (pick < 95) begin
      it = base_req(OP_POLL);
      it.transaction_id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : sb.live_id();
    end else if (pick < 97) begin
      it = base_req(OP_CANCEL);
      it.owner_id = 8'($urandom_range(0, 4));
    end else begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      it = in_item_t'(raw[$bits(in_item_t)-1:0]);
      it.now_ms = clock_ms;
    end
    return it;
  endfunction

  initial begin : stimulus
    in_item_t it;
    logic [15:0] settings[5];
    sb = new();
    idling = 1;
    hold_req = 0;
    clock_ms = 0;
    sent = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(base_req(OP_SUBMIT));
    send_req(base_req(OP_TICK));
    it = base_req(OP_SUBMIT); it.owner_id = 0; send_req(it);
    it = base_req(OP_SUBMIT); it.priority_req = 4; send_req(it);
    it = base_req(OP_SUBMIT); it.timeout_ms = 9; send_req(it);
    it = base_req(OP_SUBMIT); it.timeout_ms = 5001; send_req(it);
    it = base_req(OP_SUBMIT); it.retry_limit = 4; send_req(it);
    it = base_req(OP_SUBMIT); it.quiet_ms = 1001; send_req(it);
    it = base_req(OP_SUBMIT); it.guard_ms = 5001; send_req(it);
    it = base_req(OP_SUBMIT);
    it.owner_id = 8'hFF; it.priority_req = 3; it.timeout_ms = 10;
    it.retry_limit = 3; it.quiet_ms = 1000; it.guard_ms = 5000;
    send_req(it);
    it = base_req(OP_SUBMIT); it.timeout_ms = 5000; send_req(it);
    it = base_req(OP_POLL); it.transaction_id = 0; send_req(it);
    it = base_req(OP_POLL); it.transaction_id = 16'hFFFF; send_req(it);
    it = base_req(OP_POLL); it.transaction_id = 1; send_req(it);
    it = base_req(OP_OUTCOME); it.event_code = EV_COUNTER; send_req(it);
    it = base_req(OP_OUTCOME); it.event_code = EV_OK; send_req(it);
    send_req(base_req(OP_TICK));
    it = base_req(OP_OUTCOME); it.event_code = EV_CRC; send_req(it);
    it = base_req(OP_SEND_EVT); it.event_code = EV_IO; send_req(it);
    it = base_req(OP_SEND_EVT); it.event_code = EV_COUNTER;
    it.transaction_id = 16'(NUM_COUNTERS); send_req(it);
    it = base_req(OP_CANCEL); it.owner_id = 0; send_req(it);
    send_req(base_req(OP_UNUSED_A));
    send_req(base_req(OP_UNUSED_B));
    it = base_req(OP_TICK); it.enabled = 0; send_req(it);

    settings[0] = 16'd0;
    settings[1] = 16'hFFFF;
    settings[2] = 16'd50;
    settings[3] = AGING_RESET;
    settings[4] = 16'($urandom_range(1, 500));
    for (int p = 0; p < 5; p++) begin
      write_aging(settings[p]);
      idling = (p < 4);
      for (int n = 0; n < 276; n++) begin
        if (p == 1 && n == 50) hold_req = 1;
        if (p == 2 && n == 100) drain();
        send_req(rand_req());
      end
    end
    drain();
    $display("Ran %0d request transactions, %0d results checked, %0d slot starts.",
             sent, sb.checked, sb.starts);
    if (sb.errors == 0) $display("** bus_transaction_scheduler: PASSED **");
    else $display("** bus_transaction_scheduler: FAILED **");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+src
src/bts_pkg.sv
src/bts_in_if.sv
src/bts_out_if.sv
src/bts_ctrl.sv
src/bts_datapath.sv
src/bus_transaction_scheduler.sv
verif/tb.sv
